@@ hdl/kwsc_pkg.sv @@
// Package for the keyword substitution cipher.
// Holds the function codes, letter constants and the controller/datapath structs.
// Depends on nothing.
package kwsc_pkg;

  localparam int AlphaCount = 26;
  localparam int LetterW    = 5;

  localparam logic [7:0] LetterA  = 8'h41;
  localparam logic [7:0] LetterZ  = 8'h5A;
  localparam logic [7:0] FoldMask = 8'hDF;

  typedef enum logic [1:0] {
    FuncClear   = 2'd0,
    FuncKey     = 2'd1,
    FuncFinish  = 2'd2,
    FuncEncrypt = 2'd3
  } func_e;

  typedef struct packed {
    logic clear;
    logic key;
    logic walk_start;
    logic walk_step;
    logic encrypt;
  } cmd_t;

  typedef struct packed {
    logic walk_last;
  } status_t;

endpackage

@@ hdl/kwsc_req_if.sv @@
// Request channel of the keyword substitution cipher: function code and byte.
// Depends on nothing.
interface kwsc_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [7:0] byte_in;

  modport source (output valid, output func, output byte_in, input ready);
  modport sink (input valid, input func, input byte_in, output ready);
endinterface

@@ hdl/kwsc_rsp_if.sv @@
// Result channel of the keyword substitution cipher: one substituted byte.
// Depends on nothing.
interface kwsc_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] cipher_byte;

  modport source (output valid, output cipher_byte, input ready);
  modport sink (input valid, input cipher_byte, output ready);
endinterface

@@ hdl/keyword_substitution_cipher.sv @@
// Top level of the keyword substitution cipher.
// Joins kwsc_ctrl and kwsc_datapath; depends on kwsc_pkg, kwsc_req_if, kwsc_rsp_if.
//
// Requests arrive on req_i with a function code and a byte: clear, keyword byte,
// finish alphabet or encrypt byte. Only an encrypt request gives a result, which
// is presented on rsp_o from an output register in the cycle after acceptance.
// Text streams at one byte per cycle while the receiver takes each result. A
// finish request walks the 26 letters in a counter, one per cycle, and holds
// ready low until the table is full.
// A one-entry result register parts the two channels: a new request is taken
// while a result waits if that result is taken in the same cycle; while the
// receiver stalls with a result pending, ready stays low and the result holds.
// After reset the table is the identity alphabet, the used-letter mask is empty
// and the fill count is full, so keyword bytes are ignored until a clear.
module keyword_substitution_cipher (
  input logic      clk_i,
  input logic      rst_ni,
  kwsc_req_if.sink   req_i,
  kwsc_rsp_if.source rsp_o
);
  import kwsc_pkg::*;

  cmd_t    cmd;
  status_t status;

  kwsc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_func_i   (req_i.func),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  kwsc_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .byte_in_i     (req_i.byte_in),
    .status_o      (status),
    .cipher_byte_o (rsp_o.cipher_byte)
  );

endmodule

@@ hdl/kwsc_ctrl.sv @@
// Controller of the keyword substitution cipher: request handshake, finish walk
// state machine and result valid flag. Depends on kwsc_pkg.
module kwsc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [1:0]        in_func_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  kwsc_pkg::status_t status_i,
  output kwsc_pkg::cmd_t    cmd_o
);
  import kwsc_pkg::*;

  localparam logic StIdle = 1'b0;
  localparam logic StWalk = 1'b1;

  logic state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic accept;

  assign in_ready_o  = (state_q == StIdle) && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign accept      = in_valid_i && in_ready_o;

  always_comb begin
    cmd_o.clear      = accept && (in_func_i == FuncClear);
    cmd_o.key        = accept && (in_func_i == FuncKey);
    cmd_o.walk_start = accept && (in_func_i == FuncFinish);
    cmd_o.encrypt    = accept && (in_func_i == FuncEncrypt);
    cmd_o.walk_step  = (state_q == StWalk);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (cmd_o.walk_start) begin
          state_d = StWalk;
        end
      end
      StWalk: begin
        if (status_i.walk_last) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    if (cmd_o.encrypt) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_no_accept_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StWalk) |-> !accept)
    else $error("request accepted during finish walk");

  a_walk_entered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.walk_start |=> (state_q == StWalk))
    else $error("finish request did not start the walk");

  a_valid_from_encrypt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(cmd_o.encrypt))
    else $error("result raised without an encrypt request");

endmodule

@@ hdl/kwsc_datapath.sv @@
// Datapath of the keyword substitution cipher: used-letter mask, fill count,
// cipher table, walk counter and result register. Depends on kwsc_pkg.
module kwsc_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  kwsc_pkg::cmd_t    cmd_i,
  input  logic [7:0]        byte_in_i,
  output kwsc_pkg::status_t status_o,
  output logic [7:0]        cipher_byte_o
);
  import kwsc_pkg::*;

  logic [AlphaCount-1:0] used_q, used_d;
  logic [LetterW-1:0]    fill_q, fill_d;
  logic [LetterW-1:0]    walk_q, walk_d;
  logic [LetterW-1:0]    table_q [AlphaCount];
  logic [7:0]            out_q, out_d;

  logic [7:0]         folded;
  logic               is_letter;
  logic [LetterW-1:0] idx;
  logic               fill_full;
  logic               key_new;
  logic               walk_new;
  logic               wr_en;
  logic [LetterW-1:0] wr_letter;

  assign folded    = byte_in_i & FoldMask;
  assign is_letter = (folded >= LetterA) && (folded <= LetterZ);
  assign idx       = LetterW'(folded - LetterA);
  assign fill_full = (fill_q >= LetterW'(AlphaCount));

  assign key_new   = cmd_i.key && is_letter && !used_q[idx];
  assign walk_new  = cmd_i.walk_step && !used_q[walk_q];
  assign wr_en     = (key_new || walk_new) && !fill_full;
  assign wr_letter = cmd_i.walk_step ? walk_q : idx;

  assign status_o.walk_last = (walk_q == LetterW'(AlphaCount - 1)) || fill_full;
  assign cipher_byte_o      = out_q;

  always_comb begin
    used_d = used_q;
    fill_d = fill_q;
    if (cmd_i.clear) begin
      used_d = '0;
      fill_d = '0;
    end else if (wr_en) begin
      used_d[wr_letter] = 1'b1;
      fill_d            = fill_q + LetterW'(1);
    end
  end

  always_comb begin
    walk_d = walk_q;
    if (cmd_i.walk_start) begin
      walk_d = '0;
    end else if (cmd_i.walk_step) begin
      walk_d = walk_q + LetterW'(1);
    end
  end

  always_comb begin
    if (is_letter) begin
      out_d = LetterA + {3'b000, table_q[idx]};
    end else begin
      out_d = byte_in_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
      fill_q <= LetterW'(AlphaCount);
      walk_q <= '0;
      for (int k = 0; k < AlphaCount; k++) begin
        table_q[k] <= LetterW'(k);
      end
    end else begin
      used_q <= used_d;
      fill_q <= fill_d;
      walk_q <= walk_d;
      if (wr_en) begin
        table_q[fill_q] <= wr_letter;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.encrypt) begin
      out_q <= out_d;
    end
  end

  a_fill_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= LetterW'(AlphaCount))
    else $error("fill count beyond the alphabet");

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.clear |=> (fill_q == '0) && (used_q == '0))
    else $error("clear did not empty the table");

endmodule
